[hw/rtl/rgb_led_blink_sequencer_unit_macros.svh]
// ----------------------------------------------------------------------------
// RGB LED blink sequencer assertion macros
// Shared concurrent assertion forms, gated by the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_BLINK_SEQUENCER_UNIT_MACROS_SVH
`define RGB_LED_BLINK_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication
`define RLBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlbs assertion failed");

// next-cycle implication
`define RLBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlbs assertion failed");

`endif

[hw/rtl/rlbs_pkg.sv]
// ----------------------------------------------------------------------------
// RGB LED blink sequencer package
// Widths, command and mode codes, register indexes and the config bundle.
// ----------------------------------------------------------------------------
package rlbs_pkg;

  localparam int CMD_W       = 3;
  localparam int COLOR_W     = 24;
  localparam int DUR_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int COUNT_WIDTH = 16;

  localparam logic [DUR_W-1:0] BLINK_DUR_RST = DUR_W'(200);
  localparam logic [DUR_W-1:0] CONT_DUR_RST  = DUR_W'(500);

  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_COLOR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_SOLID  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BLINK      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_BLINK_TWICE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BLINK_CONT = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLINK_DUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CONT_DUR  = 2'd1;

  typedef enum logic [1:0] {
    MODE_SOLID = 2'd0,
    MODE_ONCE  = 2'd1,
    MODE_TWICE = 2'd2,
    MODE_CONT  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [DUR_W-1:0] blink_dur;
    logic [DUR_W-1:0] cont_dur;
  } cfg_t;

endpackage

[hw/rtl/rlbs_cfg.sv]
// ----------------------------------------------------------------------------
// RGB LED blink sequencer configuration registers
// Holds the blink and continuous durations written over the config channel.
// ----------------------------------------------------------------------------
module rlbs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlbs_pkg::DUR_W-1:0]     cfg_data,
  output rlbs_pkg::cfg_t                 cfg
);

  rlbs_pkg::cfg_t cfg_r;
  rlbs_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rlbs_pkg::CFG_IDX_BLINK_DUR: cfg_nxt.blink_dur = cfg_data;
        rlbs_pkg::CFG_IDX_CONT_DUR:  cfg_nxt.cont_dur  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_dur <= rlbs_pkg::BLINK_DUR_RST;
      cfg_r.cont_dur  <= rlbs_pkg::CONT_DUR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hw/rtl/rlbs_engine.sv]
// ----------------------------------------------------------------------------
// RGB LED blink sequencer engine
// Mode, phase, colours and elapsed counter; applies one command or tick a step.
// ----------------------------------------------------------------------------
`include "rgb_led_blink_sequencer_unit_macros.svh"

module rlbs_engine #(
  parameter int COUNT_WIDTH = rlbs_pkg::COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [rlbs_pkg::CMD_W-1:0]   cmd,
  input  logic [rlbs_pkg::COLOR_W-1:0] color,
  input  rlbs_pkg::cfg_t               cfg,
  output logic [rlbs_pkg::COLOR_W-1:0] led_color,
  output logic                         led_written
);

  localparam int CMP_W = (COUNT_WIDTH > rlbs_pkg::DUR_W) ? COUNT_WIDTH : rlbs_pkg::DUR_W;

  rlbs_pkg::mode_t              mode_r, mode_nxt;
  logic                         phase_on_r, phase_on_nxt;
  logic [rlbs_pkg::COLOR_W-1:0] blink_color_r, blink_color_nxt;
  logic [rlbs_pkg::COLOR_W-1:0] base_color_r, base_color_nxt;
  logic [rlbs_pkg::COLOR_W-1:0] shown_color_r, shown_color_nxt;
  logic [COUNT_WIDTH-1:0]       elapsed_r, elapsed_nxt;
  logic [COUNT_WIDTH-1:0]       elapsed_inc;
  logic [CMP_W-1:0]             inc_ext, blink_ext, cont_ext;
  logic                         written;

  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + COUNT_WIDTH'(1);
  assign inc_ext     = CMP_W'(elapsed_inc);
  assign blink_ext   = CMP_W'(cfg.blink_dur);
  assign cont_ext    = CMP_W'(cfg.cont_dur);

  always_comb begin
    mode_nxt        = mode_r;
    phase_on_nxt    = phase_on_r;
    blink_color_nxt = blink_color_r;
    base_color_nxt  = base_color_r;
    shown_color_nxt = shown_color_r;
    elapsed_nxt     = elapsed_r;
    written         = 1'b0;
    unique case (cmd)
      rlbs_pkg::CMD_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (mode_r != rlbs_pkg::MODE_SOLID && inc_ext >= blink_ext) begin
          unique case (mode_r)
            rlbs_pkg::MODE_CONT: begin
              if (inc_ext >= cont_ext) begin
                phase_on_nxt    = !phase_on_r;
                elapsed_nxt     = '0;
                shown_color_nxt = phase_on_r ? '0 : blink_color_r;
                written         = 1'b1;
              end
            end
            rlbs_pkg::MODE_TWICE: begin
              elapsed_nxt = '0;
              written     = 1'b1;
              if (phase_on_r) begin
                phase_on_nxt    = 1'b0;
                shown_color_nxt = '0;
              end else begin
                phase_on_nxt    = 1'b1;
                mode_nxt        = rlbs_pkg::MODE_ONCE;
                shown_color_nxt = blink_color_r;
              end
            end
            rlbs_pkg::MODE_ONCE: begin
              phase_on_nxt    = 1'b0;
              elapsed_nxt     = '0;
              blink_color_nxt = '0;
              mode_nxt        = rlbs_pkg::MODE_SOLID;
              shown_color_nxt = base_color_r;
              written         = 1'b1;
            end
            default: ;
          endcase
        end
      end
      rlbs_pkg::CMD_SET_COLOR: begin
        base_color_nxt = color;
        if (mode_r == rlbs_pkg::MODE_SOLID) begin
          shown_color_nxt = color;
          written         = 1'b1;
        end
      end
      rlbs_pkg::CMD_CLEAR: begin
        mode_nxt        = rlbs_pkg::MODE_SOLID;
        phase_on_nxt    = 1'b0;
        blink_color_nxt = '0;
        elapsed_nxt     = '0;
        base_color_nxt  = '0;
        shown_color_nxt = '0;
        written         = 1'b1;
      end
      rlbs_pkg::CMD_SET_SOLID: begin
        mode_nxt        = rlbs_pkg::MODE_SOLID;
        base_color_nxt  = color;
        shown_color_nxt = color;
        written         = 1'b1;
      end
      rlbs_pkg::CMD_BLINK, rlbs_pkg::CMD_BLINK_TWICE, rlbs_pkg::CMD_BLINK_CONT: begin
        priority if (cmd == rlbs_pkg::CMD_BLINK) begin
          mode_nxt = rlbs_pkg::MODE_ONCE;
        end else if (cmd == rlbs_pkg::CMD_BLINK_TWICE) begin
          mode_nxt = rlbs_pkg::MODE_TWICE;
        end else begin
          mode_nxt = rlbs_pkg::MODE_CONT;
        end
        blink_color_nxt = color;
        elapsed_nxt     = '0;
        phase_on_nxt    = 1'b1;
        shown_color_nxt = color;
        written         = 1'b1;
      end
      default: ;
    endcase
  end

  assign led_color   = shown_color_nxt;
  assign led_written = written;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= rlbs_pkg::MODE_SOLID;
      phase_on_r    <= 1'b0;
      blink_color_r <= '0;
      base_color_r  <= '0;
      shown_color_r <= '0;
      elapsed_r     <= '0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      phase_on_r    <= phase_on_nxt;
      blink_color_r <= blink_color_nxt;
      base_color_r  <= base_color_nxt;
      shown_color_r <= shown_color_nxt;
      elapsed_r     <= elapsed_nxt;
    end
  end

  `RLBS_ASSERT_NEXT(a_clear_goes_dark, clk, rst_n, step && cmd == rlbs_pkg::CMD_CLEAR, mode_r == rlbs_pkg::MODE_SOLID && shown_color_r == '0 && elapsed_r == '0)
  `RLBS_ASSERT_NOW(a_solid_tick_quiet, clk, rst_n, cmd == rlbs_pkg::CMD_TICK && mode_r == rlbs_pkg::MODE_SOLID, !led_written && led_color == shown_color_r)
  `RLBS_ASSERT_NEXT(a_blink_start_lit, clk, rst_n, step && (cmd == rlbs_pkg::CMD_BLINK || cmd == rlbs_pkg::CMD_BLINK_TWICE || cmd == rlbs_pkg::CMD_BLINK_CONT), phase_on_r && shown_color_r == blink_color_r && elapsed_r == '0)

endmodule

[hw/rtl/rgb_led_blink_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// RGB LED blink sequencer unit
// Input register, sequencing engine and result register around one LED colour.
// ----------------------------------------------------------------------------
// Takes one tick or command per cycle unless results stall and returns exactly
// one result for each: the colour on the LED after the item and whether the
// item wrote the LED. An item waits in the input register, steps the engine, and
// its result is held in the result register until taken; the engine state
// update sets the sustained rate of one item per clock while out_ready is high,
// and the input register lets a new item enter while a result waits.
// Configuration writes are taken at any time but belong in idle periods.
`include "rgb_led_blink_sequencer_unit_macros.svh"

module rgb_led_blink_sequencer_unit #(
  parameter int COUNT_WIDTH = rlbs_pkg::COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rlbs_pkg::CMD_W-1:0]     in_cmd,
  input  logic [rlbs_pkg::COLOR_W-1:0]   in_color,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rlbs_pkg::COLOR_W-1:0]   out_led_color,
  output logic                           out_led_written,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlbs_pkg::DUR_W-1:0]     cfg_data
);

  rlbs_pkg::cfg_t               cfg;
  logic                         in_valid_r, in_valid_nxt;
  logic [rlbs_pkg::CMD_W-1:0]   in_cmd_r;
  logic [rlbs_pkg::COLOR_W-1:0] in_color_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [rlbs_pkg::COLOR_W-1:0] out_led_color_r;
  logic                         out_led_written_r;
  logic [rlbs_pkg::COLOR_W-1:0] led_color;
  logic                         led_written;
  logic                         advance;

  rlbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rlbs_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .cmd         (in_cmd_r),
    .color       (in_color_r),
    .cfg         (cfg),
    .led_color   (led_color),
    .led_written (led_written)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign in_valid_nxt  = (in_valid && in_ready) || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r   <= in_cmd;
      in_color_r <= in_color;
    end
    if (advance) begin
      out_led_color_r   <= led_color;
      out_led_written_r <= led_written;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_color   = out_led_color_r;
  assign out_led_written = out_led_written_r;

  `RLBS_ASSERT_NEXT(a_stage_holds, clk, rst_n,
                    in_valid_r && out_valid_r && !out_ready,
                    in_valid_r && $stable(in_cmd_r) && $stable(in_color_r))

endmodule

[test/rgb_led_blink_sequencer_unit_tb.sv]
// ----------------------------------------------------------------------------
// RGB LED blink sequencer unit testbench
// Drives ticks and LED commands through the input channel, sets the two blink
// durations between phases and checks every result against a cycle-free
// prediction of the LED sequencing held in a scoreboard.
// ----------------------------------------------------------------------------
module rgb_led_blink_sequencer_unit_tb;
  import rlbs_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_UNUSED     = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 2'd3;
  localparam logic [COLOR_W-1:0]   BLACK          = '0;
  localparam logic [COLOR_W-1:0]   WHITE          = '1;
  localparam int                   CYCLE_LIMIT    = 600000;
  localparam int                   MAX_REPORTS    = 10;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic               written;
  } led_result_t;

  class blink_scoreboard;
    logic [DUR_W-1:0]       blink_dur;
    logic [DUR_W-1:0]       cont_dur;
    mode_t                  mode;
    logic                   phase_on;
    logic [COLOR_W-1:0]     blink_col;
    logic [COLOR_W-1:0]     base_col;
    logic [COLOR_W-1:0]     shown;
    logic [COUNT_WIDTH-1:0] elapsed;
    led_result_t            expected_leds[$];
    int                     mismatches;
    int                     checked;
    int                     led_writes;
    int                     cmd_count[8];

    function new();
      blink_dur  = BLINK_DUR_RST;
      cont_dur   = CONT_DUR_RST;
      mode       = MODE_SOLID;
      phase_on   = 1'b0;
      blink_col  = '0;
      base_col   = '0;
      shown      = '0;
      elapsed    = '0;
      mismatches = 0;
      checked    = 0;
      led_writes = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] data);
      if (idx == CFG_IDX_BLINK_DUR) blink_dur = data;
      else if (idx == CFG_IDX_CONT_DUR) cont_dur = data;
    endfunction

    function void start_blink(logic [COLOR_W-1:0] c, mode_t m);
      mode      = m;
      blink_col = c;
      elapsed   = '0;
      phase_on  = 1'b1;
      shown     = c;
    endfunction

    function bit advance_tick();
      if (elapsed != '1) elapsed = elapsed + 1'b1;
      if (mode == MODE_SOLID) return 1'b0;
      if (32'(elapsed) < 32'(blink_dur)) return 1'b0;
      case (mode)
        MODE_CONT: begin
          if (32'(elapsed) < 32'(cont_dur)) return 1'b0;
          phase_on = !phase_on;
          elapsed  = '0;
          shown    = phase_on ? blink_col : BLACK;
        end
        MODE_TWICE: begin
          if (phase_on) begin
            phase_on = 1'b0;
            elapsed  = '0;
            shown    = BLACK;
          end else begin
            phase_on = 1'b1;
            elapsed  = '0;
            mode     = MODE_ONCE;
            shown    = blink_col;
          end
        end
        default: begin
          phase_on  = 1'b0;
          elapsed   = '0;
          blink_col = '0;
          mode      = MODE_SOLID;
          shown     = base_col;
        end
      endcase
      return 1'b1;
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [COLOR_W-1:0] c);
      led_result_t r;
      r.written = 1'b0;
      cmd_count[cmd]++;
      case (cmd)
        CMD_TICK: r.written = advance_tick();
        CMD_SET_COLOR: begin
          base_col = c;
          if (mode == MODE_SOLID) begin
            shown     = c;
            r.written = 1'b1;
          end
        end
        CMD_CLEAR: begin
          mode      = MODE_SOLID;
          phase_on  = 1'b0;
          blink_col = '0;
          elapsed   = '0;
          base_col  = '0;
          shown     = '0;
          r.written = 1'b1;
        end
        CMD_SET_SOLID: begin
          mode      = MODE_SOLID;
          base_col  = c;
          shown     = c;
          r.written = 1'b1;
        end
        CMD_BLINK: begin
          start_blink(c, MODE_ONCE);
          r.written = 1'b1;
        end
        CMD_BLINK_TWICE: begin
          start_blink(c, MODE_TWICE);
          r.written = 1'b1;
        end
        CMD_BLINK_CONT: begin
          start_blink(c, MODE_CONT);
          r.written = 1'b1;
        end
        default: ;
      endcase
      r.color = shown;
      expected_leds.push_back(r);
    endfunction

    function void check_led(logic [COLOR_W-1:0] c, logic w);
      led_result_t e;
      if (expected_leds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: led_color=%06h led_written=%0b", c, w);
        return;
      end
      e = expected_leds.pop_front();
      checked++;
      if (w) led_writes++;
      if (c !== e.color || w !== e.written) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch at result %0d: led_color exp %06h got %06h, %s %0b got %0b",
                   checked, e.color, c, "led_written exp", e.written, w);
      end
    endfunction

    function int pending();
      return expected_leds.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_cmd;
  logic [COLOR_W-1:0]   in_color;
  logic                 out_valid;
  logic                 out_ready;
  logic [COLOR_W-1:0]   out_led_color;
  logic                 out_led_written;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0]     cfg_data;

  blink_scoreboard sb;
  bit              idle_on;
  int              cycles;
  int              settings;

  rgb_led_blink_sequencer_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_led_color   (out_led_color),
    .out_led_written (out_led_written),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_cmd, in_color);
      if (out_valid && out_ready) sb.check_led(out_led_color, out_led_written);
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [COLOR_W-1:0] c);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd   = cmd;
    in_color = c;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_durations(logic [DUR_W-1:0] bd, logic [DUR_W-1:0] cd);
    write_reg(CFG_IDX_BLINK_DUR, bd);
    write_reg(CFG_IDX_CONT_DUR, cd);
    settings++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(CMD_TICK, COLOR_W'($urandom));
  endtask

  // Mostly a command followed by a random run of up to 3*max(durations)+4 ticks, capped at 80.
  task automatic run_blink_traffic(int n_items);
    int                 sent;
    int                 span;
    int                 run;
    logic [COLOR_W-1:0] c;
    sent = 0;
    span = 3 * ((sb.blink_dur > sb.cont_dur) ? int'(sb.blink_dur) : int'(sb.cont_dur)) + 4;
    if (span > 80) span = 80;
    while (sent < n_items) begin
      c = COLOR_W'($urandom);
      if ($urandom_range(0, 3) == 0) c = ($urandom_range(0, 1) != 0) ? WHITE : BLACK;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: send_item(CMD_BLINK, c);
        4, 5, 6:    send_item(CMD_BLINK_TWICE, c);
        7, 8, 9:    send_item(CMD_BLINK_CONT, c);
        10, 11:     send_item(CMD_SET_COLOR, c);
        12:         send_item(CMD_SET_SOLID, c);
        13:         send_item(CMD_CLEAR, c);
        14:         send_item(CMD_UNUSED, c);
        default:    send_item(CMD_TICK, c);
      endcase
      run = $urandom_range(0, span);
      send_ticks(run);
      sent += run + 1;
    end
  endtask

  initial begin
    sb        = new();
    idle_on   = 1'b0;
    cycles    = 0;
    settings  = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_cmd    = CMD_TICK;
    in_color  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IDX_BLINK_DUR;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every command, extremes and blink patterns at short durations
    send_item(CMD_TICK, WHITE);
    send_item(CMD_SET_COLOR, WHITE);
    send_item(CMD_SET_SOLID, BLACK);
    send_item(CMD_SET_COLOR, 24'hA5A5A5);
    send_item(CMD_UNUSED, WHITE);
    set_durations(16'd2, 16'd3);
    send_item(CMD_BLINK, 24'h123456);
    send_item(CMD_SET_COLOR, 24'h00FF00);
    send_ticks(2);
    send_item(CMD_BLINK_TWICE, 24'hFF0000);
    send_ticks(6);
    send_item(CMD_BLINK_CONT, 24'h0000FF);
    send_ticks(6);
    send_item(CMD_CLEAR, WHITE);

    idle_on = 1'b1;
    write_reg(CFG_IDX_SPARE0, 16'hFFFF);
    write_reg(CFG_IDX_SPARE1, DUR_W'($urandom));
    set_durations(16'd0, 16'd0);
    run_blink_traffic(120);
    set_durations(16'd1, 16'd1);
    run_blink_traffic(120);
    set_durations(16'd4, 16'd2);
    run_blink_traffic(120);
    set_durations(16'd3, 16'd9);
    run_blink_traffic(120);
    set_durations(DUR_W'($urandom_range(1, 12)), DUR_W'($urandom_range(1, 24)));
    run_blink_traffic(120);

    // longer waits: one continuous toggle and one blink played out to the end
    idle_on = 1'b0;
    set_durations(16'd40, 16'd60);
    send_item(CMD_BLINK_CONT, WHITE);
    send_ticks(61);
    send_item(CMD_BLINK, 24'h5A5A5A);
    send_ticks(41);

    set_durations(16'd6, 16'd11);
    run_blink_traffic(100);
    settle();
    repeat (8) @(posedge clk);

    $display("tb: %0d results checked over %0d duration settings, %0d wrote the LED",
             sb.checked, settings, sb.led_writes);
    $display("tb: blink once %0d, twice %0d, continuous %0d, unused command %0d",
             sb.cmd_count[CMD_BLINK], sb.cmd_count[CMD_BLINK_TWICE],
             sb.cmd_count[CMD_BLINK_CONT], sb.cmd_count[CMD_UNUSED]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
